>>> rtl/lowest_hash_top_k_macros.svh
// Assertion macros for the lowest_hash_top_k checker.
// Depends on nothing; included by the checker file only.
`ifndef LOWEST_HASH_TOP_K_MACROS_SVH
`define LOWEST_HASH_TOP_K_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lowest_hash_top_k assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LHT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lowest_hash_top_k assertion failed");

`endif

>>> rtl/lht_pkg.sv
// Shared types and constants of the lowest_hash_top_k block.
// Used by every RTL module and by the checker; depends on nothing.
package lht_pkg;

    localparam int TOP_MAX_DEF = 16;
    localparam int HASH_BYTES  = 32;
    localparam int HASH_W      = HASH_BYTES * 8;
    localparam int WORD_W      = 64;
    localparam int HEIGHT_W    = 32;
    localparam int RANK_W      = 5;
    localparam int KEEP_W      = 5;

    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(10);

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REPORT = 1'b1;

    typedef struct packed {
        logic                valid;
        logic [HASH_W-1:0]   hash;
        logic [HEIGHT_W-1:0] height;
    } lht_entry_t;

    typedef enum logic {
        LHT_IDLE,
        LHT_REPORT
    } lht_state_t;

endpackage

>>> rtl/lht_cell.sv
// One slot of the sorted insertion chain: holds a hash, its height and a valid bit.
// Depends on lht_pkg; instantiated in a row by lowest_hash_top_k.
module lht_cell
    import lht_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       insert,
    input  logic       in_range,
    input  lht_entry_t new_entry,
    input  lht_entry_t prev_entry,
    input  logic       prev_take,
    output lht_entry_t entry,
    output logic       take
);

    logic                valid_reg, valid_next;
    logic [HASH_W-1:0]   hash_reg, hash_next;
    logic [HEIGHT_W-1:0] height_reg, height_next;
    logic                valid_eff;

    assign valid_eff    = valid_reg & in_range;
    assign take         = !valid_eff || (new_entry.hash < hash_reg);
    assign entry.valid  = valid_eff;
    assign entry.hash   = hash_reg;
    assign entry.height = height_reg;

    always_comb begin
        valid_next  = valid_eff;
        hash_next   = hash_reg;
        height_next = height_reg;
        if (insert && in_range) begin
            if (prev_take) begin
                valid_next  = prev_entry.valid;
                hash_next   = prev_entry.hash;
                height_next = prev_entry.height;
            end else if (take) begin
                valid_next  = 1'b1;
                hash_next   = new_entry.hash;
                height_next = new_entry.height;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hash_reg   <= hash_next;
        height_reg <= height_next;
    end

endmodule

>>> rtl/lht_report.sv
// Report sequencer: walks the chain in rank order into an output register.
// Depends on lht_pkg; instantiated by lowest_hash_top_k.
module lht_report
    import lht_pkg::*;
#(
    parameter int TOP_MAX = TOP_MAX_DEF,
    parameter int KW      = $clog2(TOP_MAX + 1),
    parameter int IW      = (TOP_MAX > 1) ? $clog2(TOP_MAX) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [KW-1:0]       k_eff,
    input  lht_entry_t          entries [TOP_MAX],
    output logic                busy,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [RANK_W-1:0]   m_rank,
    output logic                m_entry_valid,
    output logic [HEIGHT_W-1:0] m_out_height,
    output logic [WORD_W-1:0]   m_out_word0,
    output logic [WORD_W-1:0]   m_out_word1,
    output logic [WORD_W-1:0]   m_out_word2,
    output logic [WORD_W-1:0]   m_out_word3,
    output logic                m_last_of_report
);

    lht_state_t          state_reg, state_next;
    logic [KW-1:0]       cnt_reg, cnt_next;
    logic                m_valid_reg, m_valid_next;
    logic [RANK_W-1:0]   rank_reg, rank_next;
    logic                ev_reg, ev_next;
    logic [HEIGHT_W-1:0] height_reg, height_next;
    logic [HASH_W-1:0]   hash_reg, hash_next;
    logic                last_reg, last_next;
    logic                load;
    logic                at_last;
    lht_entry_t          rd_entry;

    assign at_last  = (cnt_reg == (k_eff - KW'(1)));
    assign rd_entry = entries[cnt_reg[IW-1:0]];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            LHT_IDLE: begin
                if (start) begin
                    state_next = LHT_REPORT;
                end
            end
            LHT_REPORT: begin
                if (load && at_last) begin
                    state_next = LHT_IDLE;
                end
            end
            default: state_next = LHT_IDLE;
        endcase
    end

    always_comb begin
        load = 1'b0;
        busy = 1'b0;
        case (state_reg)
            LHT_IDLE: begin
                load = 1'b0;
                busy = 1'b0;
            end
            LHT_REPORT: begin
                load = !m_valid_reg || m_ready;
                busy = 1'b1;
            end
            default: begin
                load = 1'b0;
                busy = 1'b0;
            end
        endcase
    end

    always_comb begin
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        rank_next    = rank_reg;
        ev_next      = ev_reg;
        height_next  = height_reg;
        hash_next    = hash_reg;
        last_next    = last_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (start) begin
            cnt_next = '0;
        end else if (load) begin
            cnt_next     = cnt_reg + KW'(1);
            m_valid_next = 1'b1;
            rank_next    = RANK_W'(32'(cnt_reg) + 32'd1);
            ev_next      = rd_entry.valid;
            height_next  = rd_entry.valid ? rd_entry.height : '0;
            hash_next    = rd_entry.valid ? rd_entry.hash : '0;
            last_next    = at_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= LHT_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rank_reg   <= rank_next;
        ev_reg     <= ev_next;
        height_reg <= height_next;
        hash_reg   <= hash_next;
        last_reg   <= last_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_rank           = rank_reg;
    assign m_entry_valid    = ev_reg;
    assign m_out_height     = height_reg;
    assign m_out_word0      = hash_reg[WORD_W-1:0];
    assign m_out_word1      = hash_reg[2*WORD_W-1:WORD_W];
    assign m_out_word2      = hash_reg[3*WORD_W-1:2*WORD_W];
    assign m_out_word3      = hash_reg[4*WORD_W-1:3*WORD_W];
    assign m_last_of_report = last_reg;

endmodule

>>> rtl/lowest_hash_top_k.sv
// Top level of lowest_hash_top_k: keep_count register, insertion chain and report sequencer.
// Depends on lht_pkg, lht_cell and lht_report.
//
// Keeps the keep_count smallest 256-bit hashes (word3 most significant; keep_count is
// clamped to 1..TOP_MAX) with their heights in a row of TOP_MAX cells sorted in ascending
// order; equal hashes keep arrival order. An insert takes effect as it is accepted, and
// inserts can follow each other every cycle, since all cells compare against the new hash
// in parallel and shift toward the tail by one. A report transaction produces that many
// results at up to one per cycle from the output register, and no new transaction is taken
// until the last of them has been loaded into that register. Unfilled ranks report
// entry_valid low with zero data. Lowering keep_count drops the tail entries at once.
module lowest_hash_top_k
    import lht_pkg::*;
#(
    parameter int TOP_MAX = TOP_MAX_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [KEEP_W-1:0]   cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_req_type,
    input  logic [WORD_W-1:0]   s_hash_word0,
    input  logic [WORD_W-1:0]   s_hash_word1,
    input  logic [WORD_W-1:0]   s_hash_word2,
    input  logic [WORD_W-1:0]   s_hash_word3,
    input  logic [HEIGHT_W-1:0] s_block_height,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [RANK_W-1:0]   m_rank,
    output logic                m_entry_valid,
    output logic [HEIGHT_W-1:0] m_out_height,
    output logic [WORD_W-1:0]   m_out_word0,
    output logic [WORD_W-1:0]   m_out_word1,
    output logic [WORD_W-1:0]   m_out_word2,
    output logic [WORD_W-1:0]   m_out_word3,
    output logic                m_last_of_report
);

    localparam int KW = $clog2(TOP_MAX + 1);

    logic [KEEP_W-1:0] keep_count_reg, keep_count_next;
    logic [KW-1:0]     k_eff;
    logic              busy;
    logic              accept;
    logic              insert;
    logic              start;
    lht_entry_t        new_entry;
    lht_entry_t        entries [TOP_MAX];
    logic [TOP_MAX-1:0] takes;
    logic [TOP_MAX-1:0] in_range;

    assign keep_count_next = cfg_wr_en ? cfg_wr_data : keep_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_count_reg <= KEEP_RESET;
        end else begin
            keep_count_reg <= keep_count_next;
        end
    end

    always_comb begin
        if (keep_count_reg == '0) begin
            k_eff = KW'(1);
        end else if (32'(keep_count_reg) > TOP_MAX) begin
            k_eff = KW'(TOP_MAX);
        end else begin
            k_eff = KW'(keep_count_reg);
        end
    end

    assign s_ready = !busy;
    assign accept  = s_valid && s_ready;
    assign insert  = accept && (s_req_type == REQ_INSERT);
    assign start   = accept && (s_req_type == REQ_REPORT);

    assign new_entry.valid  = 1'b1;
    assign new_entry.hash   = {s_hash_word3, s_hash_word2, s_hash_word1, s_hash_word0};
    assign new_entry.height = s_block_height;

    for (genvar i = 0; i < TOP_MAX; i++) begin : g_cell
        assign in_range[i] = (32'(k_eff) > i);
        if (i == 0) begin : g_head
            lht_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .insert     (insert),
                .in_range   (in_range[i]),
                .new_entry  (new_entry),
                .prev_entry ('0),
                .prev_take  (1'b0),
                .entry      (entries[i]),
                .take       (takes[i])
            );
        end else begin : g_body
            lht_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .insert     (insert),
                .in_range   (in_range[i]),
                .new_entry  (new_entry),
                .prev_entry (entries[i-1]),
                .prev_take  (takes[i-1]),
                .entry      (entries[i]),
                .take       (takes[i])
            );
        end
    end

    lht_report #(
        .TOP_MAX (TOP_MAX)
    ) u_report (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .start            (start),
        .k_eff            (k_eff),
        .entries          (entries),
        .busy             (busy),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_rank           (m_rank),
        .m_entry_valid    (m_entry_valid),
        .m_out_height     (m_out_height),
        .m_out_word0      (m_out_word0),
        .m_out_word1      (m_out_word1),
        .m_out_word2      (m_out_word2),
        .m_out_word3      (m_out_word3),
        .m_last_of_report (m_last_of_report)
    );

endmodule

>>> rtl/lht_checker.sv
// Port-level assertions for lowest_hash_top_k, attached by the bind at the end.
// Depends on lht_pkg and lowest_hash_top_k_macros.svh.
`include "lowest_hash_top_k_macros.svh"

module lht_checker
    import lht_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [RANK_W-1:0]   m_rank,
    input logic                m_entry_valid,
    input logic [HEIGHT_W-1:0] m_out_height,
    input logic [WORD_W-1:0]   m_out_word0,
    input logic [WORD_W-1:0]   m_out_word1,
    input logic [WORD_W-1:0]   m_out_word2,
    input logic [WORD_W-1:0]   m_out_word3,
    input logic                m_last_of_report
);

    logic [HASH_W-1:0]                 out_hash;
    logic [RANK_W+HEIGHT_W+HASH_W+1:0] out_bundle;
    logic                              out_zero;

    assign out_hash   = {m_out_word3, m_out_word2, m_out_word1, m_out_word0};
    assign out_bundle = {m_rank, m_entry_valid, m_out_height, out_hash, m_last_of_report};
    assign out_zero   = (m_out_height == '0) && (out_hash == '0);

    `LHT_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(out_bundle))
    `LHT_ASSERT_IMP(a_busy_mid_report, aclk, aresetn, m_valid && !m_last_of_report, !s_ready)
    `LHT_ASSERT_IMP(a_unfilled_zero, aclk, aresetn, m_valid && !m_entry_valid, out_zero)
    `LHT_ASSERT_IMP(a_rank_nonzero, aclk, aresetn, m_valid, m_rank != '0)

endmodule

bind lowest_hash_top_k lht_checker u_lht_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench for lowest_hash_top_k: drives insert and report transactions
// with random idling on both channels and checks every ranked result against a predictor.
// Depends on lht_pkg and the lowest_hash_top_k RTL.
module testbench;
    import lht_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE       = 8;
    localparam int RANDOM_ITEMS = 440;
    localparam int QUIET_ITEMS  = 60;

    typedef struct packed {
        logic [RANK_W-1:0]   rank;
        logic                entry_valid;
        logic [HEIGHT_W-1:0] height;
        logic [HASH_W-1:0]   hash;
        logic                last;
    } rank_result_t;

    class top_k_scoreboard;
        logic [HASH_W-1:0]   kept_hash[TOP_MAX_DEF];
        logic [HEIGHT_W-1:0] kept_height[TOP_MAX_DEF];
        int                  fill;
        logic [KEEP_W-1:0]   keep_reg;
        rank_result_t        ranked_q[$];
        int                  errors;
        int                  inserts;
        int                  reports;
        int                  keep_writes;
        int                  results_checked;

        function new();
            fill = 0;
            keep_reg = KEEP_RESET;
            errors = 0;
            inserts = 0;
            reports = 0;
            keep_writes = 0;
            results_checked = 0;
        endfunction

        function int active_count();
            if (keep_reg == 0) begin
                return 1;
            end
            if (keep_reg > TOP_MAX_DEF) begin
                return TOP_MAX_DEF;
            end
            return int'(keep_reg);
        endfunction

        function void write_keep(logic [KEEP_W-1:0] value);
            keep_writes++;
            keep_reg = value;
            if (fill > active_count()) begin
                fill = active_count();
            end
        endfunction

        function void insert_hash(logic [HASH_W-1:0] h, logic [HEIGHT_W-1:0] ht);
            int pos;
            int tail;
            pos = 0;
            while (pos < fill && !(h < kept_hash[pos])) begin
                pos++;
            end
            if (fill < active_count()) begin
                tail = fill;
                fill++;
            end else begin
                if (pos >= fill) begin
                    return;
                end
                tail = fill - 1;
            end
            for (int i = tail; i > pos; i--) begin
                kept_hash[i] = kept_hash[i-1];
                kept_height[i] = kept_height[i-1];
            end
            kept_hash[pos] = h;
            kept_height[pos] = ht;
        endfunction

        function void note_input(logic req, logic [HASH_W-1:0] h, logic [HEIGHT_W-1:0] ht);
            rank_result_t r;
            int k;
            if (req == REQ_INSERT) begin
                inserts++;
                insert_hash(h, ht);
                return;
            end
            reports++;
            k = active_count();
            for (int i = 0; i < k; i++) begin
                r.rank = RANK_W'(i + 1);
                r.entry_valid = (i < fill);
                r.height = (i < fill) ? kept_height[i] : '0;
                r.hash = (i < fill) ? kept_hash[i] : '0;
                r.last = (i + 1 == k);
                ranked_q = {ranked_q, r};
            end
        endfunction

        function void compare_field(string name, logic [WORD_W-1:0] exp_v,
                                    logic [WORD_W-1:0] act_v);
            if (act_v !== exp_v) begin
                errors++;
                $display("%0t: mismatch on %s, expected %h, actual %h",
                         $realtime, name, exp_v, act_v);
            end
        endfunction

        function void check_result(rank_result_t act);
            rank_result_t exp_r;
            results_checked++;
            if (ranked_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual rank %0d hash %h",
                         $realtime, act.rank, act.hash);
                return;
            end
            exp_r = ranked_q.pop_front();
            compare_field("rank", WORD_W'(exp_r.rank), WORD_W'(act.rank));
            compare_field("entry_valid", WORD_W'(exp_r.entry_valid), WORD_W'(act.entry_valid));
            compare_field("out_height", WORD_W'(exp_r.height), WORD_W'(act.height));
            compare_field("out_word0", exp_r.hash[63:0], act.hash[63:0]);
            compare_field("out_word1", exp_r.hash[127:64], act.hash[127:64]);
            compare_field("out_word2", exp_r.hash[191:128], act.hash[191:128]);
            compare_field("out_word3", exp_r.hash[255:192], act.hash[255:192]);
            compare_field("last_of_report", WORD_W'(exp_r.last), WORD_W'(act.last));
        endfunction

        function int pending();
            return ranked_q.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [KEEP_W-1:0]   cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    logic                s_req_type;
    logic [WORD_W-1:0]   s_hash_word0;
    logic [WORD_W-1:0]   s_hash_word1;
    logic [WORD_W-1:0]   s_hash_word2;
    logic [WORD_W-1:0]   s_hash_word3;
    logic [HEIGHT_W-1:0] s_block_height;
    logic                m_valid;
    logic                m_ready;
    logic [RANK_W-1:0]   m_rank;
    logic                m_entry_valid;
    logic [HEIGHT_W-1:0] m_out_height;
    logic [WORD_W-1:0]   m_out_word0;
    logic [WORD_W-1:0]   m_out_word1;
    logic [WORD_W-1:0]   m_out_word2;
    logic [WORD_W-1:0]   m_out_word3;
    logic                m_last_of_report;

    top_k_scoreboard     sb;
    logic                quiet;
    logic [HASH_W-1:0]   hash_pool[$];

    lowest_hash_top_k u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_hash_word0     (s_hash_word0),
        .s_hash_word1     (s_hash_word1),
        .s_hash_word2     (s_hash_word2),
        .s_hash_word3     (s_hash_word3),
        .s_block_height   (s_block_height),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_rank           (m_rank),
        .m_entry_valid    (m_entry_valid),
        .m_out_height     (m_out_height),
        .m_out_word0      (m_out_word0),
        .m_out_word1      (m_out_word1),
        .m_out_word2      (m_out_word2),
        .m_out_word3      (m_out_word3),
        .m_last_of_report (m_last_of_report)
    );

    initial begin
        aclk = 1'b0;
        forever begin
            #5 aclk = ~aclk;
        end
    end

    initial begin
        #8_000_000;
        $display("testbench failed");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) begin
                sb.write_keep(cfg_wr_data);
            end
            if (s_valid && s_ready) begin
                sb.note_input(s_req_type,
                              {s_hash_word3, s_hash_word2, s_hash_word1, s_hash_word0},
                              s_block_height);
            end
            if (m_valid && m_ready) begin
                sb.check_result('{rank: m_rank, entry_valid: m_entry_valid,
                                  height: m_out_height,
                                  hash: {m_out_word3, m_out_word2, m_out_word1, m_out_word0},
                                  last: m_last_of_report});
            end
        end
    end

    initial begin
        int run;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            if (quiet || $urandom_range(0, 2) != 0) begin
                run = quiet ? 1 : $urandom_range(1, 20);
                m_ready <= 1'b1;
            end else begin
                run = $urandom_range(1, 10);
                m_ready <= 1'b0;
            end
            repeat (run) @(negedge aclk);
        end
    end

    function automatic logic [HASH_W-1:0] pick_hash();
        logic [HASH_W-1:0] h;
        h = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 7))
            0: h = {192'd0, 48'd0, 16'($urandom)};
            1: if (hash_pool.size() > 0) h = hash_pool[$urandom_range(0, hash_pool.size() - 1)];
            2: if (hash_pool.size() > 0) begin
                h = hash_pool[$urandom_range(0, hash_pool.size() - 1)];
                h[7:0] = h[7:0] ^ 8'($urandom_range(1, 3));
            end
            3: h = {$urandom, $urandom, 192'd0};
            4: h = $urandom_range(0, 1) ? '0 : '1;
            default: ;
        endcase
        hash_pool = {hash_pool, h};
        if (hash_pool.size() > 32) begin
            void'(hash_pool.pop_front());
        end
        return h;
    endfunction

    task automatic send_item(input logic req, input logic [HASH_W-1:0] h,
                             input logic [HEIGHT_W-1:0] ht);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_hash_word0 <= h[63:0];
        s_hash_word1 <= h[127:64];
        s_hash_word2 <= h[191:128];
        s_hash_word3 <= h[255:192];
        s_block_height <= ht;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic send_report();
        send_item(REQ_REPORT, {$urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom}, $urandom);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.pending() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic set_keep(input logic [KEEP_W-1:0] value);
        wait_drained();
        cfg_wr_data <= value;
        cfg_wr_en <= 1'b1;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [KEEP_W-1:0] pick_keep();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return KEEP_W'(1);
            2: return KEEP_W'(TOP_MAX_DEF);
            3: return '1;
            4: return KEEP_W'($urandom_range(TOP_MAX_DEF + 1, 30));
            default: return KEEP_W'($urandom_range(2, TOP_MAX_DEF - 1));
        endcase
    endfunction

    initial begin
        logic [HASH_W-1:0] tie_hash;
        int sent;
        int burst;
        sb = new();
        quiet = 1'b0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_req_type = REQ_INSERT;
        s_hash_word0 = '0;
        s_hash_word1 = '0;
        s_hash_word2 = '0;
        s_hash_word3 = '0;
        s_block_height = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        tie_hash = {64'h0123_4567_89ab_cdef, 64'h0, 64'hffff_0000_ffff_0000, 64'h5a5a};
        send_report();
        send_item(REQ_INSERT, '1, '1);
        send_item(REQ_INSERT, '0, 32'd1);
        send_item(REQ_INSERT, tie_hash, 32'd2);
        send_item(REQ_INSERT, tie_hash, 32'd3);
        send_item(REQ_INSERT, {64'd1, 192'd0}, 32'd4);
        send_item(REQ_INSERT, {192'd0, 64'hffff_ffff_ffff_ffff}, 32'd5);
        send_report();

        set_keep(KEEP_W'(1));
        send_item(REQ_INSERT, tie_hash, 32'd6);
        send_item(REQ_INSERT, '1, 32'd7);
        send_report();
        set_keep('0);
        send_report();
        set_keep('1);
        send_item(REQ_INSERT, tie_hash, 32'd8);
        send_item(REQ_INSERT, {64'd2, 192'd0}, 32'd9);
        send_item(REQ_INSERT, {192'd0, 64'd3}, 32'd10);
        send_item(REQ_INSERT, '1, 32'd11);
        send_report();
        set_keep(KEEP_W'(2));
        send_report();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            set_keep(pick_keep());
            burst = $urandom_range(20, 60);
            for (int j = 0; j < burst && sent < RANDOM_ITEMS; j++) begin
                quiet = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
                if ($urandom_range(0, 7) == 0) begin
                    send_report();
                end else begin
                    send_item(REQ_INSERT, pick_hash(), $urandom);
                end
                sent++;
                if (!quiet && $urandom_range(0, 49) == 0) begin
                    wait_drained();
                end
            end
        end
        send_report();

        wait_drained();
        $display("Ran %0d inserts and %0d reports over %0d keep_count writes.",
                 sb.inserts, sb.reports, sb.keep_writes);
        $display("Checked %0d ranked results, %0d mismatches.", sb.results_checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
